// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property holds on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg
// shared constants and types of the bisection root finder
// ----------------------------------------------------------------------------
package pbr_pkg;
   localparam int MAX_TERMS_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int XW = 32;
   localparam int VW = 48;
   localparam logic [46:0] MAG_MAX = {47{1'b1}};
   localparam logic [1:0] ST_CONVERGED = 2'd0;
   localparam logic [1:0] ST_NO_ROOT = 2'd1;
   localparam logic [1:0] ST_LIMIT = 2'd2;
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_SOLVE = 1'b1;
   localparam logic [1:0] REG_TERM_COUNT = 2'd0;
   localparam logic [1:0] REG_TOLERANCE = 2'd1;
   localparam logic [1:0] REG_MAX_ITER = 2'd2;

   typedef struct packed {
      logic start;
      logic [XW-1:0] x;
   } eval_req_type;

   typedef struct packed {
      logic done;
      logic signed [VW-1:0] value;
   } eval_rsp_type;
endpackage

// ===== rtl/core/pbr_if.sv =====
// ----------------------------------------------------------------------------
// pbr_req_if / pbr_rsp_if
// valid/ready channels of the root finder
// ----------------------------------------------------------------------------
interface pbr_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [3:0] term_index;
   logic signed [15:0] coefficient;
   logic [3:0] exponent;
   logic signed [31:0] interval_low;
   logic signed [31:0] interval_high;
   modport source (output valid, action, term_index, coefficient, exponent,
                   interval_low, interval_high, input ready);
   modport sink (input valid, action, term_index, coefficient, exponent,
                 interval_low, interval_high, output ready);
endinterface

interface pbr_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] root;
   logic signed [47:0] value_at_root;
   logic [7:0] iterations;
   logic [1:0] status;
   modport source (output valid, root, value_at_root, iterations, status,
                   input ready);
   modport sink (input valid, root, value_at_root, iterations, status,
                 output ready);
endinterface

// ===== rtl/core/pbr_ram.sv =====
// ----------------------------------------------------------------------------
// pbr_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module pbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/pbr_eval.sv =====
// ----------------------------------------------------------------------------
// pbr_eval
// polynomial evaluator, one term and one power step at a time; the power steps
// share one multiplier, and the term product has its own
// ----------------------------------------------------------------------------
module pbr_eval import pbr_pkg::*; #(
   parameter int MAX_TERMS = MAX_TERMS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  eval_req_type        req,
   input  logic [4:0]          term_count,
   output logic [AW-1:0]       raddr,
   input  logic signed [15:0]  coef_rd,
   input  logic [3:0]          exp_rd,
   output eval_rsp_type        rsp
);
   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int SH = 24 - FRAC_BITS;
   localparam logic [CW-1:0] MAXT = CW'(MAX_TERMS);

   typedef enum logic [2:0] {S_IDLE, S_ADDR, S_READ, S_MUL_HI, S_MUL_LO,
                             S_TERM, S_ACC} state_type;

   state_type state_in, state_ff;
   logic [CW-1:0] idx_in, idx_ff, n_in, n_ff;
   logic [31:0] xm_in, xm_ff;
   logic neg_in, neg_ff;
   logic [46:0] p_in, p_ff;
   logic [3:0] k_in, k_ff, e_in, e_ff;
   logic signed [15:0] c_in, c_ff;
   logic [55:0] hx_in, hx_ff;
   logic signed [VW-1:0] acc_in, acc_ff;
   logic signed [64:0] term_in, term_ff;
   logic done_in, done_ff;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [71:0] hx_sh;
   logic [63:0] lo_sum;
   logic signed [48:0] sum49;
   logic signed [47:0] sp;

   always_comb begin
      mul_a = 32'(xm_ff);
      mul_b = 32'(p_ff[23:0]);
      if (state_ff == S_MUL_HI) begin
         mul_b = {9'd0, p_ff[46:24]};
      end
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign raddr = idx_ff[AW-1:0];
   assign sp = (neg_ff && e_ff[0]) ? -$signed({1'b0, p_ff}) : $signed({1'b0, p_ff});

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      xm_in = xm_ff;
      neg_in = neg_ff;
      p_in = p_ff;
      k_in = k_ff;
      e_in = e_ff;
      c_in = c_ff;
      hx_in = hx_ff;
      acc_in = acc_ff;
      term_in = term_ff;
      done_in = 1'b0;
      hx_sh = 72'(hx_ff) << SH;
      lo_sum = 64'(hx_sh) + (mul_p >> FRAC_BITS);
      sum49 = 49'(acc_ff) + 49'(term_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               neg_in = req.x[31];
               xm_in = req.x[31] ? 32'(-req.x) : req.x;
               idx_in = '0;
               acc_in = '0;
               n_in = (32'(term_count) > MAX_TERMS) ? MAXT : CW'(term_count);
               if (n_in == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR: state_in = S_READ;
         S_READ: begin
            c_in = coef_rd;
            e_in = exp_rd;
            k_in = '0;
            p_in = 47'(1) << FRAC_BITS;
            state_in = (exp_rd == '0) ? S_TERM : S_MUL_HI;
         end
         S_MUL_HI: begin
            hx_in = mul_p[55:0];
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            if (hx_ff > 56'(MAG_MAX >> SH) || mul_p[63:56] != '0) begin
               p_in = MAG_MAX;
            end else if (lo_sum > 64'(MAG_MAX)) begin
               p_in = MAG_MAX;
            end else begin
               p_in = lo_sum[46:0];
            end
            k_in = k_ff + 4'd1;
            state_in = (k_ff + 4'd1 == e_ff) ? S_TERM : S_MUL_HI;
         end
         S_TERM: begin
            term_in = 65'(c_ff) * 65'(sp);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (term_ff > 65'sh7FFFFFFFFFFF) begin
               sum49 = 49'(acc_ff) + 49'sh7FFFFFFFFFFF;
            end else if (term_ff < -65'sh800000000000) begin
               sum49 = 49'(acc_ff) - 49'sh800000000000;
            end
            if (sum49 > 49'sh7FFFFFFFFFFF) begin
               acc_in = 48'sh7FFFFFFFFFFF;
            end else if (sum49 < -49'sh800000000000) begin
               acc_in = 48'sh800000000000;
            end else begin
               acc_in = sum49[47:0];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_in == n_ff) begin
               done_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_ADDR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      n_ff <= n_in;
      xm_ff <= xm_in;
      neg_ff <= neg_in;
      p_ff <= p_in;
      k_ff <= k_in;
      e_ff <= e_in;
      c_ff <= c_in;
      hx_ff <= hx_in;
      acc_ff <= acc_in;
      term_ff <= term_in;
   end

   assign rsp.done = done_ff;
   assign rsp.value = acc_ff;
endmodule

// ===== rtl/core/polynomial_bisection_root_top.sv =====
// ----------------------------------------------------------------------------
// polynomial_bisection_root_top
// bisection root finder for an integer coefficient polynomial
// ----------------------------------------------------------------------------
// channel  direction  content
// req      in         load term or solve on interval
// rsp      out        root, value, iterations, status
// csr      in         apb term_count, tolerance, max_iterations
// a load writes one term into the rams; a solve takes (iterations+3)
// evaluations, or two when the interval holds no root; each evaluation reads
// the n terms and raises x to each term's exponent e in power steps
// reset is synchronous; no clearing pass is needed
// req is held off while a solve runs or a result waits on rsp
module polynomial_bisection_root_top import pbr_pkg::*; #(
   parameter int MAX_TERMS = MAX_TERMS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pbr_req_if.sink     req,
   pbr_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   `include "assert_macros.svh"
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   typedef enum logic [2:0] {S_IDLE, S_EV_LO, S_EV_HI, S_CHECK, S_EV_MID,
                             S_DECIDE, S_OUT} state_type;

   state_type state_ff, state_in;
   logic [4:0] tc_ff;
   logic [46:0] tol_ff;
   logic [7:0] maxi_ff;
   logic signed [31:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [47:0] vlo_ff, vlo_in, vhi_ff, vhi_in, vmid_ff, vmid_in;
   logic [7:0] it_ff, it_in;
   logic [1:0] st_ff, st_in;
   logic rv_ff, rv_in;
   eval_req_type ereq;
   eval_rsp_type ersp;
   logic [AW-1:0] raddr;
   logic signed [15:0] coef_rd;
   logic [3:0] exp_rd;
   logic we;
   logic [AW-1:0] waddr;
   logic signed [32:0] hsum;
   logic [47:0] vabs;
   logic csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[4:3];
   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         REG_TERM_COUNT: csr_prdata = 64'(tc_ff);
         REG_TOLERANCE:  csr_prdata = 64'(tol_ff);
         REG_MAX_ITER:   csr_prdata = 64'(maxi_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign we = req.valid && req.ready && req.action == ACT_LOAD
               && 32'(req.term_index) < 32'(MAX_TERMS);
   assign waddr = AW'(req.term_index);

   pbr_ram #(.WIDTH(16), .DEPTH(MAX_TERMS)) u_coef (
      .clock(clock), .we(we), .waddr(waddr), .wdata(req.coefficient),
      .raddr(raddr), .rdata(coef_rd));
   pbr_ram #(.WIDTH(4), .DEPTH(MAX_TERMS)) u_exp (
      .clock(clock), .we(we), .waddr(waddr), .wdata(req.exponent),
      .raddr(raddr), .rdata(exp_rd));

   pbr_eval #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_eval (
      .clock(clock), .reset(reset), .req(ereq), .term_count(tc_ff),
      .raddr(raddr), .coef_rd(coef_rd), .exp_rd(exp_rd), .rsp(ersp));

   assign hsum = 33'(lo_ff) + 33'(hi_ff);
   assign vabs = vmid_ff[47] ? 48'(-vmid_ff) : vmid_ff;

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      vlo_in = vlo_ff;
      vhi_in = vhi_ff;
      vmid_in = vmid_ff;
      it_in = it_ff;
      st_in = st_ff;
      rv_in = rv_ff;
      ereq.start = 1'b0;
      ereq.x = lo_ff;
      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready && req.action == ACT_SOLVE) begin
               lo_in = req.interval_low;
               hi_in = req.interval_high;
               it_in = '0;
               state_in = S_EV_LO;
               ereq.start = 1'b1;
               ereq.x = req.interval_low;
            end
         end
         S_EV_LO: begin
            if (ersp.done) begin
               vlo_in = ersp.value;
               ereq.start = 1'b1;
               ereq.x = hi_ff;
               state_in = S_EV_HI;
            end
         end
         S_EV_HI: begin
            if (ersp.done) begin
               vhi_in = ersp.value;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (vlo_ff != '0 && vhi_ff != '0 && vlo_ff[47] == vhi_ff[47]) begin
               mid_in = '0;
               vmid_in = '0;
               st_in = ST_NO_ROOT;
               state_in = S_OUT;
            end else begin
               mid_in = hsum[32:1];
               ereq.start = 1'b1;
               ereq.x = hsum[32:1];
               state_in = S_EV_MID;
            end
         end
         S_EV_MID: begin
            ereq.x = mid_ff;
            if (ersp.done) begin
               vmid_in = ersp.value;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (vabs <= 48'(tol_ff)) begin
               st_in = ST_CONVERGED;
               state_in = S_OUT;
            end else if (it_ff >= maxi_ff) begin
               st_in = ST_LIMIT;
               state_in = S_OUT;
            end else begin
               if (vlo_ff == '0 || (vmid_ff != '0 && vlo_ff[47] != vmid_ff[47])) begin
                  hi_in = mid_ff;
                  vhi_in = vmid_ff;
               end else begin
                  lo_in = mid_ff;
                  vlo_in = vmid_ff;
               end
               it_in = it_ff + 8'd1;
               state_in = S_CHECK;
            end
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         tc_ff <= 5'd1;
         tol_ff <= 47'd655;
         maxi_ff <= 8'd64;
         lo_ff <= '0;
         hi_ff <= '0;
         mid_ff <= '0;
         vlo_ff <= '0;
         vhi_ff <= '0;
         vmid_ff <= '0;
         it_ff <= '0;
         st_ff <= ST_CONVERGED;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         mid_ff <= mid_in;
         vlo_ff <= vlo_in;
         vhi_ff <= vhi_in;
         vmid_ff <= vmid_in;
         it_ff <= it_in;
         st_ff <= st_in;
         if (csr_wr) begin
            unique case (csr_idx)
               REG_TERM_COUNT: tc_ff <= csr_pwdata[4:0];
               REG_TOLERANCE:  tol_ff <= csr_pwdata[46:0];
               REG_MAX_ITER:   maxi_ff <= csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.root = mid_ff;
   assign rsp.value_at_root = vmid_ff;
   assign rsp.iterations = it_ff;
   assign rsp.status = st_ff;

   `ASSERT_CLK(a_ready_idle, clock, reset, req.ready |-> state_ff == S_IDLE, "ready while busy")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp.valid && !rsp.ready) |=> rsp.valid, "rsp dropped")
   `ASSERT_CLK(a_noroot_zero, clock, reset, !(rsp.valid && rsp.status == ST_NO_ROOT && rsp.iterations != '0), "no_root iterations")
endmodule
